### rtl/rmt_pkg.sv
// Package for the reverse map table: shared constants, status codes and the
// controller to datapath command and status structs. No dependencies.
`timescale 1ns / 1ps
package rmt_pkg;
	localparam int BUCKETS_DEF = 1024;
	localparam int WAYS_DEF = 16;
	localparam int PAGE_BYTES_DEF = 64;
	localparam int MAP_BYTES_DEF = 64;
	localparam int ADDR_W = 48;
	localparam int SLOT_W = 9;
	localparam int KIND_W = 2;
	localparam int STATUS_W = 3;

	localparam logic [STATUS_W-1:0] ST_INSTALLED = 3'd0;
	localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL = 3'd2;
	localparam logic [STATUS_W-1:0] ST_WHACK_PTE = 3'd3;
	localparam logic [STATUS_W-1:0] ST_WHACK_PROC = 3'd4;
	localparam logic [STATUS_W-1:0] ST_NONE = 3'd5;

	localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd0;
	localparam logic [KIND_W-1:0] KIND_PAGE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_MAP = 2'd2;
	localparam logic [KIND_W-1:0] KIND_PROC = 2'd3;

	typedef struct packed {
		logic clr_step;
		logic load;
		logic index_sel;
		logic read;
		logic eval;
		logic write_install;
		logic write_clear;
		logic emit_whack;
		logic emit_simple;
		logic [STATUS_W-1:0] simple_status;
	} rmt_cmd_t;

	typedef struct packed {
		logic clr_done;
		logic way_last;
		logic hit_dup;
		logic hit_empty;
		logic hit_whack;
		logic found_empty;
		logic any_whack;
		logic is_install;
		logic kind_zero;
	} rmt_stat_t;
endpackage

### rtl/rmt_datapath.sv
// Datapath of the reverse map table: entry memory, bucket hash, way counter
// and result registers. Depends on rmt_pkg.
`timescale 1ns / 1ps
module rmt_datapath #(
	parameter int BUCKETS = rmt_pkg::BUCKETS_DEF,
	parameter int WAYS = rmt_pkg::WAYS_DEF,
	parameter int PAGE_RECORD_BYTES = rmt_pkg::PAGE_BYTES_DEF,
	parameter int MAP_RECORD_BYTES = rmt_pkg::MAP_BYTES_DEF
) (
	input logic clk,
	input logic arst_n,
	input rmt_pkg::rmt_cmd_t cmd,
	output rmt_pkg::rmt_stat_t stat,
	input logic action,
	input logic [rmt_pkg::KIND_W-1:0] kind,
	input logic [rmt_pkg::ADDR_W-1:0] target_addr,
	input logic [rmt_pkg::ADDR_W-1:0] table_addr,
	input logic [rmt_pkg::SLOT_W-1:0] slot_index,
	input logic [rmt_pkg::ADDR_W-1:0] process_addr,
	output logic strobe,
	output logic [rmt_pkg::STATUS_W-1:0] status,
	output logic [rmt_pkg::ADDR_W-1:0] table_addr_out,
	output logic [rmt_pkg::SLOT_W-1:0] slot_out,
	output logic [rmt_pkg::ADDR_W-1:0] process_out,
	output logic last
);
	localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int DEPTH = BUCKETS * WAYS;
	localparam int IW = $clog2(DEPTH);
	localparam int AW = rmt_pkg::ADDR_W;
	localparam int HW = AW + 1;

	typedef struct packed {
		logic [rmt_pkg::KIND_W-1:0] kind;
		logic [AW-1:0] target;
		logic [AW-1:0] owner;
		logic [rmt_pkg::SLOT_W-1:0] slot;
	} entry_t;

	entry_t mem [DEPTH];
	entry_t rd_q;
	logic [IW-1:0] clr_q;
	logic [BW-1:0] bucket_q;
	logic [WW-1:0] way_q;
	logic [WW-1:0] empty_way_q;
	logic found_empty_q;
	logic any_q;
	logic action_q;
	logic [rmt_pkg::KIND_W-1:0] kind_q;
	logic [AW-1:0] target_q;
	logic [AW-1:0] owner_q;
	logic [rmt_pkg::SLOT_W-1:0] slot_q;
	logic [AW-1:0] quot_q;
	logic [AW-1:0] quot_page;
	logic [AW-1:0] quot_map;
	logic [IW-1:0] addr;
	logic [IW-1:0] wr_addr;
	logic [HW-1:0] ways_max;
	entry_t new_entry;

	assign quot_page = AW'(target_addr / PAGE_RECORD_BYTES);
	assign quot_map = AW'(target_addr / MAP_RECORD_BYTES);
	assign ways_max = HW'(WAYS - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_step) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= action;
			kind_q <= kind;
			target_q <= target_addr;
			owner_q <= (kind == rmt_pkg::KIND_PROC) ? process_addr : table_addr;
			slot_q <= (kind == rmt_pkg::KIND_PROC) ? '0 : slot_index;
			quot_q <= (kind == rmt_pkg::KIND_PAGE) ? quot_page : quot_map;
		end
		if (cmd.index_sel) begin
			bucket_q <= BW'(quot_q % BUCKETS);
			way_q <= '0;
			found_empty_q <= 1'b0;
			any_q <= 1'b0;
		end else if (cmd.eval) begin
			if (stat.hit_empty && !found_empty_q) begin
				found_empty_q <= 1'b1;
				empty_way_q <= way_q;
			end
			if (stat.hit_whack) begin
				any_q <= 1'b1;
			end
			if (!stat.way_last) begin
				way_q <= way_q + 1'b1;
			end
		end
	end

	assign addr = IW'(bucket_q) * IW'(WAYS) + IW'(way_q);
	assign wr_addr = cmd.clr_step ? clr_q :
		cmd.write_install ? IW'(bucket_q) * IW'(WAYS) + IW'(empty_way_q) : addr;
	assign new_entry = cmd.write_install ?
		entry_t'{kind: kind_q, target: target_q, owner: owner_q, slot: slot_q} : '0;

	always_ff @(posedge clk) begin
		if (cmd.clr_step || cmd.write_install || cmd.write_clear) begin
			mem[wr_addr] <= new_entry;
		end
		if (cmd.read) begin
			rd_q <= mem[addr];
		end
	end

	assign stat.clr_done = (clr_q == IW'(DEPTH - 1));
	assign stat.way_last = (HW'(way_q) == ways_max);
	assign stat.hit_dup = (rd_q.kind == kind_q) && (rd_q.target == target_q) &&
		(rd_q.owner == owner_q) && (rd_q.slot == slot_q);
	assign stat.hit_empty = (rd_q.kind == rmt_pkg::KIND_EMPTY);
	assign stat.hit_whack = (rd_q.kind != rmt_pkg::KIND_EMPTY) && (rd_q.target == target_q);
	assign stat.found_empty = found_empty_q;
	assign stat.any_whack = any_q;
	assign stat.is_install = !action_q;
	assign stat.kind_zero = (kind_q == rmt_pkg::KIND_EMPTY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
		end else begin
			strobe <= cmd.emit_simple || cmd.emit_whack;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_simple) begin
			status <= cmd.simple_status;
			table_addr_out <= '0;
			slot_out <= '0;
			process_out <= '0;
			last <= 1'b1;
		end else if (cmd.emit_whack) begin
			if (rd_q.kind == rmt_pkg::KIND_PROC) begin
				status <= rmt_pkg::ST_WHACK_PROC;
				table_addr_out <= '0;
				slot_out <= '0;
				process_out <= rd_q.owner;
			end else begin
				status <= rmt_pkg::ST_WHACK_PTE;
				table_addr_out <= rd_q.owner;
				slot_out <= rd_q.slot;
				process_out <= '0;
			end
			last <= 1'b0;
		end
	end
endmodule

### rtl/rmt_ctrl.sv
// Controller of the reverse map table: sequences the clearing pass and the
// per-way scan of one bucket. Depends on rmt_pkg.
`timescale 1ns / 1ps
module rmt_ctrl (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	output rmt_pkg::rmt_cmd_t cmd,
	input rmt_pkg::rmt_stat_t stat,
	output logic last_fix
);
	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_HASH = 3'd2;
	localparam logic [2:0] S_READ = 3'd3;
	localparam logic [2:0] S_EVAL = 3'd4;
	localparam logic [2:0] S_FINISH = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic pend_q;
	logic pend_d;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd = '0;
		state_d = state_q;
		pend_d = pend_q;
		last_fix = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d = S_HASH;
				end
			end
			S_HASH: begin
				cmd.index_sel = 1'b1;
				pend_d = 1'b0;
				if (stat.is_install && stat.kind_zero) begin
					cmd.emit_simple = 1'b1;
					cmd.simple_status = rmt_pkg::ST_NONE;
					state_d = S_IDLE;
				end else begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				cmd.read = 1'b1;
				state_d = S_EVAL;
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				if (stat.is_install) begin
					if (stat.hit_dup) begin
						cmd.emit_simple = 1'b1;
						cmd.simple_status = rmt_pkg::ST_DUPLICATE;
						state_d = S_IDLE;
					end else if (stat.way_last) begin
						state_d = S_FINISH;
					end else begin
						state_d = S_READ;
					end
				end else begin
					if (stat.hit_whack) begin
						cmd.write_clear = 1'b1;
						cmd.emit_whack = 1'b1;
						pend_d = 1'b1;
					end
					if (stat.way_last) begin
						state_d = S_FINISH;
					end else begin
						state_d = S_READ;
					end
				end
			end
			S_FINISH: begin
				if (stat.is_install) begin
					cmd.emit_simple = 1'b1;
					if (stat.found_empty) begin
						cmd.write_install = 1'b1;
						cmd.simple_status = rmt_pkg::ST_INSTALLED;
					end else begin
						cmd.simple_status = rmt_pkg::ST_FULL;
					end
				end else if (!stat.any_whack) begin
					cmd.emit_simple = 1'b1;
					cmd.simple_status = rmt_pkg::ST_NONE;
				end
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (state_q == S_EVAL && !stat.is_install && stat.way_last && pend_q
			&& !stat.hit_whack) begin
			last_fix = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			pend_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q <= pend_d;
		end
	end
endmodule

### rtl/reverse_map_table.sv
// Top level of the reverse map table: controller, datapath and the output
// delay stage that marks the final whack word. Depends on rmt_pkg, rmt_ctrl
// and rmt_datapath.
//
// Usage: drive the input word and raise start while busy is low; the word
// is taken at that edge. Results come out on status, table_addr_out,
// slot_out, process_out and last, each marked by strobe for exactly one
// cycle; the receiver cannot stall. last is high on the final word of each
// input. Busy stays high through the scan (a hash state, then a read and a
// compare state per way, then a finish state) and while a whack word is
// held in the output stage, so the block takes no new item until the last
// one is through. A duplicate or an empty-kind install ends the scan early.
// Whack words wait in an output stage until the next whack word or the end
// of the scan shows whether each is the final one.
// After reset the block runs a clearing pass over all BUCKETS*WAYS entries
// (16384 entries at the defaults) with busy high before it takes any item.
`timescale 1ns / 1ps
module reverse_map_table #(
	parameter int BUCKETS = rmt_pkg::BUCKETS_DEF,
	parameter int WAYS = rmt_pkg::WAYS_DEF,
	parameter int PAGE_RECORD_BYTES = rmt_pkg::PAGE_BYTES_DEF,
	parameter int MAP_RECORD_BYTES = rmt_pkg::MAP_BYTES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic action,
	input logic [rmt_pkg::KIND_W-1:0] kind,
	input logic [rmt_pkg::ADDR_W-1:0] target_addr,
	input logic [rmt_pkg::ADDR_W-1:0] table_addr,
	input logic [rmt_pkg::SLOT_W-1:0] slot_index,
	input logic [rmt_pkg::ADDR_W-1:0] process_addr,
	output logic strobe,
	output logic [rmt_pkg::STATUS_W-1:0] status,
	output logic [rmt_pkg::ADDR_W-1:0] table_addr_out,
	output logic [rmt_pkg::SLOT_W-1:0] slot_out,
	output logic [rmt_pkg::ADDR_W-1:0] process_out,
	output logic last
);
	rmt_pkg::rmt_cmd_t cmd;
	rmt_pkg::rmt_stat_t stat;
	logic ctrl_busy;
	logic last_fix;
	logic d_strobe;
	logic [rmt_pkg::STATUS_W-1:0] d_status;
	logic [rmt_pkg::ADDR_W-1:0] d_table;
	logic [rmt_pkg::SLOT_W-1:0] d_slot;
	logic [rmt_pkg::ADDR_W-1:0] d_proc;
	logic d_last;
	logic hold_q;
	logic [rmt_pkg::STATUS_W-1:0] hold_status_q;
	logic [rmt_pkg::ADDR_W-1:0] hold_table_q;
	logic [rmt_pkg::SLOT_W-1:0] hold_slot_q;
	logic [rmt_pkg::ADDR_W-1:0] hold_proc_q;
	logic fix_q;
	logic fix_a_q;
	logic is_whack_word;

	rmt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start && !hold_q), .busy(ctrl_busy),
		.cmd(cmd), .stat(stat), .last_fix(last_fix)
	);

	rmt_datapath #(
		.BUCKETS(BUCKETS), .WAYS(WAYS),
		.PAGE_RECORD_BYTES(PAGE_RECORD_BYTES), .MAP_RECORD_BYTES(MAP_RECORD_BYTES)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.action(action), .kind(kind), .target_addr(target_addr),
		.table_addr(table_addr), .slot_index(slot_index),
		.process_addr(process_addr), .strobe(d_strobe), .status(d_status),
		.table_addr_out(d_table), .slot_out(d_slot), .process_out(d_proc),
		.last(d_last)
	);

	// Whack words carry last low from the datapath; a held word is released
	// when the next whack word arrives (not final) or when the scan ends.
	assign is_whack_word = d_strobe && !d_last;
	assign busy = ctrl_busy || hold_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= 1'b0;
			fix_q <= 1'b0;
			fix_a_q <= 1'b0;
			strobe <= 1'b0;
		end else begin
			fix_a_q <= cmd.eval && cmd.emit_whack && stat.way_last;
			fix_q <= last_fix || fix_a_q;
			strobe <= (d_strobe && d_last) || (hold_q && (is_whack_word || fix_q));
			if (is_whack_word) begin
				hold_q <= 1'b1;
			end else if (fix_q) begin
				hold_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (is_whack_word) begin
			hold_status_q <= d_status;
			hold_table_q <= d_table;
			hold_slot_q <= d_slot;
			hold_proc_q <= d_proc;
		end
		if (d_strobe && d_last) begin
			status <= d_status;
			table_addr_out <= d_table;
			slot_out <= d_slot;
			process_out <= d_proc;
			last <= 1'b1;
		end else begin
			status <= hold_status_q;
			table_addr_out <= hold_table_q;
			slot_out <= hold_slot_q;
			process_out <= hold_proc_q;
			last <= fix_q && !is_whack_word;
		end
	end

	property p_no_start_when_busy;
		@(posedge clk) disable iff (!arst_n) (ctrl_busy && hold_q) |-> busy;
	endproperty
	assert property (p_no_start_when_busy) else $error("busy dropped while held");

	property p_single_write;
		@(posedge clk) disable iff (!arst_n)
			!(cmd.write_install && cmd.write_clear);
	endproperty
	assert property (p_single_write) else $error("two writes in one cycle");

	property p_emit_excl;
		@(posedge clk) disable iff (!arst_n) !(cmd.emit_simple && cmd.emit_whack);
	endproperty
	assert property (p_emit_excl) else $error("two result sources at once");
endmodule

### tb/rmt_checker.sv
// Checker for the reverse map table: watches accepted input words and result
// words, predicts results from its own copy of the store and compares them.
// Depends on rmt_pkg.
`timescale 1ns / 1ps
module rmt_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic action,
	input logic [rmt_pkg::KIND_W-1:0] kind,
	input logic [rmt_pkg::ADDR_W-1:0] target_addr,
	input logic [rmt_pkg::ADDR_W-1:0] table_addr,
	input logic [rmt_pkg::SLOT_W-1:0] slot_index,
	input logic [rmt_pkg::ADDR_W-1:0] process_addr,
	input logic strobe,
	input logic [rmt_pkg::STATUS_W-1:0] status,
	input logic [rmt_pkg::ADDR_W-1:0] table_addr_out,
	input logic [rmt_pkg::SLOT_W-1:0] slot_out,
	input logic [rmt_pkg::ADDR_W-1:0] process_out,
	input logic last,
	output int fail_count,
	output int pending,
	output int words_seen
);
	localparam int NB = rmt_pkg::BUCKETS_DEF;
	localparam int NW = rmt_pkg::WAYS_DEF;

	typedef struct packed {
		logic [rmt_pkg::STATUS_W-1:0] st;
		logic [rmt_pkg::ADDR_W-1:0] tbl;
		logic [rmt_pkg::SLOT_W-1:0] slot;
		logic [rmt_pkg::ADDR_W-1:0] proc;
		logic lst;
	} word_t;

	logic [rmt_pkg::KIND_W-1:0] map_kind [NB*NW];
	logic [rmt_pkg::ADDR_W-1:0] map_target [NB*NW];
	logic [rmt_pkg::ADDR_W-1:0] map_owner [NB*NW];
	logic [rmt_pkg::SLOT_W-1:0] map_slot [NB*NW];
	word_t expected_words [$];

	function automatic int bucket_base(logic [rmt_pkg::ADDR_W-1:0] tgt, logic page);
		longint unsigned sz;
		sz = page ? rmt_pkg::PAGE_BYTES_DEF : rmt_pkg::MAP_BYTES_DEF;
		return int'((longint'(tgt) / sz) % NB) * NW;
	endfunction

	task automatic predict_word();
		int base;
		int n;
		bit done;
		logic [rmt_pkg::ADDR_W-1:0] own;
		logic [rmt_pkg::SLOT_W-1:0] osl;
		word_t w;
		base = bucket_base(target_addr, kind == rmt_pkg::KIND_PAGE);
		n = 0;
		done = 0;
		w = '0;
		w.lst = 1'b1;
		if (action) begin
			for (int i = base; i < base + NW; i++) begin
				if (map_kind[i] != rmt_pkg::KIND_EMPTY && map_target[i] == target_addr) begin
					w = '0;
					if (map_kind[i] == rmt_pkg::KIND_PROC) begin
						w.st = rmt_pkg::ST_WHACK_PROC;
						w.proc = map_owner[i];
					end else begin
						w.st = rmt_pkg::ST_WHACK_PTE;
						w.tbl = map_owner[i];
						w.slot = map_slot[i];
					end
					expected_words.push_back(w);
					n++;
					map_kind[i] = rmt_pkg::KIND_EMPTY;
					map_target[i] = '0;
					map_owner[i] = '0;
					map_slot[i] = '0;
				end
			end
			if (n == 0) begin
				w.st = rmt_pkg::ST_NONE;
				expected_words.push_back(w);
			end else begin
				expected_words[$].lst = 1'b1;
			end
		end else if (kind == rmt_pkg::KIND_EMPTY) begin
			w.st = rmt_pkg::ST_NONE;
			expected_words.push_back(w);
		end else begin
			own = (kind == rmt_pkg::KIND_PROC) ? process_addr : table_addr;
			osl = (kind == rmt_pkg::KIND_PROC) ? '0 : slot_index;
			w.st = rmt_pkg::ST_FULL;
			for (int i = base; i < base + NW; i++) begin
				if (!done && map_kind[i] == kind && map_target[i] == target_addr &&
						map_owner[i] == own && map_slot[i] == osl) begin
					w.st = rmt_pkg::ST_DUPLICATE;
					done = 1;
				end
			end
			for (int i = base; i < base + NW; i++) begin
				if (!done && map_kind[i] == rmt_pkg::KIND_EMPTY) begin
					map_kind[i] = kind;
					map_target[i] = target_addr;
					map_owner[i] = own;
					map_slot[i] = osl;
					w.st = rmt_pkg::ST_INSTALLED;
					done = 1;
				end
			end
			expected_words.push_back(w);
		end
	endtask

	task automatic compare_word();
		word_t e;
		if (expected_words.size() == 0) begin
			$error("result word with nothing expected: status %0d", status);
			fail_count++;
		end else begin
			e = expected_words.pop_front();
			if (status !== e.st) begin
				$error("status expected %0d actual %0d", e.st, status);
				fail_count++;
			end
			if (table_addr_out !== e.tbl) begin
				$error("table_addr_out expected %h actual %h", e.tbl, table_addr_out);
				fail_count++;
			end
			if (slot_out !== e.slot) begin
				$error("slot_out expected %h actual %h", e.slot, slot_out);
				fail_count++;
			end
			if (process_out !== e.proc) begin
				$error("process_out expected %h actual %h", e.proc, process_out);
				fail_count++;
			end
			if (last !== e.lst) begin
				$error("last expected %0d actual %0d", e.lst, last);
				fail_count++;
			end
		end
	endtask

	initial begin
		fail_count = 0;
		words_seen = 0;
		for (int i = 0; i < NB*NW; i++) begin
			map_kind[i] = '0;
			map_target[i] = '0;
			map_owner[i] = '0;
			map_slot[i] = '0;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (strobe === 1'b1) begin
				compare_word();
				words_seen++;
			end
			if (start && !busy)
				predict_word();
		end
	end

	assign pending = expected_words.size();
endmodule

### tb/tb_reverse_map_table.sv
// Testbench top for the reverse map table: drives directed and random input
// words, instantiates the block and rmt_checker, and prints the verdict.
// Depends on rmt_pkg, reverse_map_table and rmt_checker.
`timescale 1ns / 1ps
module tb_reverse_map_table;
	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	logic action = 0;
	logic [rmt_pkg::KIND_W-1:0] kind = '0;
	logic [rmt_pkg::ADDR_W-1:0] target_addr = '0;
	logic [rmt_pkg::ADDR_W-1:0] table_addr = '0;
	logic [rmt_pkg::SLOT_W-1:0] slot_index = '0;
	logic [rmt_pkg::ADDR_W-1:0] process_addr = '0;
	logic strobe;
	logic [rmt_pkg::STATUS_W-1:0] status;
	logic [rmt_pkg::ADDR_W-1:0] table_addr_out;
	logic [rmt_pkg::SLOT_W-1:0] slot_out;
	logic [rmt_pkg::ADDR_W-1:0] process_out;
	logic last;
	int fail_count;
	int pending;
	int words_seen;
	int cycles = 0;
	int items_sent = 0;
	int idle_pct = 0;
	logic [rmt_pkg::ADDR_W-1:0] targets [8];

	localparam int CYCLE_LIMIT = 400000;

	always #5 clk = ~clk;

	reverse_map_table dut (.*);

	rmt_checker checker_i (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("reverse_map_table: mismatch");
			$finish;
		end
	end

	task automatic send_word(logic act, logic [rmt_pkg::KIND_W-1:0] k,
			logic [rmt_pkg::ADDR_W-1:0] tgt, logic [rmt_pkg::ADDR_W-1:0] tbl,
			logic [rmt_pkg::SLOT_W-1:0] sl, logic [rmt_pkg::ADDR_W-1:0] prc);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		action <= act;
		kind <= k;
		target_addr <= tgt;
		table_addr <= tbl;
		slot_index <= sl;
		process_addr <= prc;
		start <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	function automatic logic [rmt_pkg::ADDR_W-1:0] rand48();
		return rmt_pkg::ADDR_W'({$urandom(), $urandom()});
	endfunction

	task automatic random_word();
		int p;
		logic [rmt_pkg::ADDR_W-1:0] tgt;
		logic [rmt_pkg::KIND_W-1:0] k;
		p = $urandom_range(99);
		tgt = targets[$urandom_range(7)];
		if (p < 8)
			tgt = rand48();
		k = rmt_pkg::KIND_W'($urandom_range(3));
		if (p < 96 && k == rmt_pkg::KIND_EMPTY)
			k = rmt_pkg::KIND_PAGE;
		send_word(p >= 70, k, tgt,
			($urandom_range(3) == 0) ? rand48() : rmt_pkg::ADDR_W'($urandom_range(3)),
			rmt_pkg::SLOT_W'($urandom_range(511)),
			($urandom_range(3) == 0) ? rand48() : rmt_pkg::ADDR_W'($urandom_range(3)));
	endtask

	initial begin
		repeat (4) @(negedge clk);
		arst_n = 1;
		// Eight targets, four of them sharing one bucket so that it fills.
		for (int i = 0; i < 4; i++)
			targets[i] = 48'h1000 + i * 64 * rmt_pkg::BUCKETS_DEF;
		for (int i = 4; i < 8; i++)
			targets[i] = rand48();
		targets[7] = '1;
		send_word(1, rmt_pkg::KIND_PAGE, '0, '0, '0, '0);
		send_word(0, rmt_pkg::KIND_EMPTY, '1, '1, '1, '1);
		send_word(0, rmt_pkg::KIND_PAGE, '0, '1, '1, '1);
		send_word(0, rmt_pkg::KIND_PAGE, '0, '1, '1, '1);
		send_word(0, rmt_pkg::KIND_MAP, '1, '1, '1, '0);
		send_word(0, rmt_pkg::KIND_PROC, '1, '0, '1, '1);
		send_word(0, rmt_pkg::KIND_PROC, '1, '0, '0, '1);
		send_word(1, rmt_pkg::KIND_MAP, '1, '0, '0, '0);
		send_word(1, rmt_pkg::KIND_PAGE, '0, '0, '0, '0);
		for (int i = 0; i < 17; i++)
			send_word(0, rmt_pkg::KIND_PAGE, targets[i % 2], rmt_pkg::ADDR_W'(i),
				rmt_pkg::SLOT_W'(i), '0);
		send_word(1, rmt_pkg::KIND_PROC, targets[0], '0, '0, '0);
		send_word(1, rmt_pkg::KIND_PAGE, targets[1], '0, '0, '0);
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = (ph == 0) ? 0 : (ph == 3) ? 6 : 84;
			repeat (106)
				random_word();
		end
		start <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		$display("Sent %0d words, checked %0d result words across installs, duplicates,",
			items_sent, words_seen);
		$display("full buckets, whacks and empty-kind words, with and without idle gaps.");
		if (fail_count == 0 && pending == 0) begin
			$display("reverse_map_table: match");
		end else begin
			$display("reverse_map_table: mismatch");
		end
		$finish;
	end
endmodule

### filelist.f
rtl/rmt_pkg.sv
rtl/rmt_datapath.sv
rtl/rmt_ctrl.sv
rtl/reverse_map_table.sv
tb/rmt_checker.sv
tb/tb_reverse_map_table.sv
